FILE: design/newton_square_root_defines.svh
// Assertion macros for the newton_square_root design files; nsr_ctrl includes them.
// Depends on nothing; every user supplies clk_i and rst_ni in its own scope.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define NSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent follows an antecedent in the same cycle.
`define NSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/nsr_pkg.sv
// Shared types and constants for the Newton-Raphson square root block.
// Used by nsr_ctrl, nsr_datapath and newton_square_root.
package nsr_pkg;

  localparam int FracBitsDefault  = 12;
  localparam int InputBitsDefault = 8;

  localparam int RootW = 16;
  localparam logic [RootW-1:0] RootMax = 16'hFFFF;

  localparam int IterW = 4;
  localparam logic [IterW-1:0] IterReset = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input item and start guess
    logic div_init;  // clear remainder, load dividend
    logic div_step;  // one restoring division bit
    logic update;    // y = (y + q) / 2
    logic out_load;  // move final guess into output register
  } nsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_zero;
  } nsr_status_t;

endpackage

FILE: design/nsr_datapath.sv
// Datapath of the square root block: guess register, bit-serial restoring
// divider, averaging update and output register. Depends on nsr_pkg.
module nsr_datapath
  import nsr_pkg::*;
#(
  parameter int FRAC_BITS  = FracBitsDefault,
  parameter int INPUT_BITS = InputBitsDefault
) (
  input  logic                  clk_i,
  input  logic [INPUT_BITS-1:0] value_i,
  input  logic                  last_item_i,
  input  nsr_cmd_t              cmd_i,
  output nsr_status_t           status_o,
  output logic [RootW-1:0]      root_o,
  output logic                  last_result_o
);

  localparam int GuessW = INPUT_BITS + FRAC_BITS;
  localparam int DivW   = INPUT_BITS + 2 * FRAC_BITS;
  localparam int ExtW   = (GuessW > RootW) ? GuessW : RootW;
  localparam logic [GuessW-1:0] GuessMax = {GuessW{1'b1}};

  logic [INPUT_BITS-1:0] x_q;
  logic                  last_q;
  logic [GuessW-1:0]     y_q, y_d;
  logic [GuessW-1:0]     rem_q, rem_d;
  logic [DivW-1:0]       div_q, div_d;
  logic [RootW-1:0]      root_q, root_d;
  logic                  out_last_q;

  logic [GuessW:0]       shifted;
  logic [GuessW:0]       diff;
  logic                  q_bit;
  logic [GuessW-1:0]     q_sat;
  logic [GuessW:0]       sum;
  logic [ExtW-1:0]       y_ext;

  always_comb begin
    // One restoring division step: bring down the next dividend bit.
    shifted = {rem_q, div_q[DivW-1]};
    diff    = shifted - {1'b0, y_q};
    q_bit   = (shifted >= {1'b0, y_q});

    // Clamp the quotient to the guess width.
    q_sat = (|div_q[DivW-1:GuessW]) ? GuessMax : div_q[GuessW-1:0];
    sum   = {1'b0, y_q} + {1'b0, q_sat};

    y_ext  = ExtW'(y_q);
    root_d = (y_ext > ExtW'(RootMax)) ? RootMax : y_ext[RootW-1:0];

    y_d   = y_q;
    rem_d = rem_q;
    div_d = div_q;
    if (cmd_i.load) begin
      y_d = GuessW'(value_i) << (FRAC_BITS - 1);
    end else if (cmd_i.update) begin
      y_d = sum[GuessW:1];
    end
    if (cmd_i.div_init) begin
      rem_d = '0;
      div_d = {x_q, {(2 * FRAC_BITS){1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_d = q_bit ? diff[GuessW-1:0] : shifted[GuessW-1:0];
      div_d = {div_q[DivW-2:0], q_bit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= value_i;
      last_q <= last_item_i;
    end
    if (cmd_i.out_load) begin
      root_q     <= root_d;
      out_last_q <= last_q;
    end
    y_q   <= y_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign status_o.y_zero = (y_q == '0);
  assign root_o          = root_q;
  assign last_result_o   = out_last_q;

endmodule

FILE: design/nsr_ctrl.sv
// Controller of the square root block: input/output handshakes, iteration
// register and step sequencing. Depends on nsr_pkg and the defines header.
`include "newton_square_root_defines.svh"

module nsr_ctrl
  import nsr_pkg::*;
#(
  parameter int DIV_BITS = InputBitsDefault + 2 * FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IterW-1:0] cfg_data_i,
  input  nsr_status_t      status_i,
  output nsr_cmd_t         cmd_o
);

  localparam int CntW = $clog2(DIV_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [IterW-1:0]  iter_cfg_q;
  logic [IterW-1:0]  iter_left_q;
  logic [CntW-1:0]   bit_cnt_q;
  logic              out_valid_q;
  logic              div_last;
  logic              in_accept;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.load     = in_valid_i;
      S_CHECK:  cmd_o.div_init = (iter_left_q != '0) && !status_i.y_zero;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_UPDATE: cmd_o.update   = 1'b1;
      S_FINISH: cmd_o.out_load = !out_valid_q || out_ready_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_cfg_q  <= IterReset;
      iter_left_q <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        iter_cfg_q <= cfg_data_i;
      end
      // Drop the result once taken; a new one may replace it in the same cycle.
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            iter_left_q <= iter_cfg_q;
            state_q     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cmd_o.div_init) begin
            bit_cnt_q <= CntW'(DIV_BITS - 1);
            state_q   <= S_DIV;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_DIV: begin
          if (bit_cnt_q == '0) begin
            state_q <= S_UPDATE;
          end else begin
            bit_cnt_q <= bit_cnt_q - 1'b1;
          end
        end
        S_UPDATE: begin
          iter_left_q <= iter_left_q - 1'b1;
          state_q     <= S_CHECK;
        end
        S_FINISH: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  assign div_last  = (state_q == S_DIV) && (bit_cnt_q == '0);
  assign in_accept = in_valid_i && in_ready_o;

  `NSR_ASSERT_SAME(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i, "result lost")
  `NSR_ASSERT_NEXT(a_div_to_update, div_last, state_q == S_UPDATE, "division did not end")
  `NSR_ASSERT_SAME(a_update_has_step, state_q == S_UPDATE, iter_left_q != '0, "no step left")
  `NSR_ASSERT_NEXT(a_accept_to_check, in_accept, state_q == S_CHECK, "item did not start")

endmodule

FILE: design/newton_square_root.sv
// Newton-Raphson square root of an unsigned integer, result in fixed point.
// Top level; depends on nsr_pkg, nsr_ctrl and nsr_datapath.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o): one item is value_i plus a
//   last_item_i flag. One item is worked on at a time; in_ready_o is high
//   while the sequencer is idle.
// - Output channel (out_valid_o / out_ready_i): one result per item, root_o
//   in unsigned fixed point with FRAC_BITS fraction bits, clamped to 16 bits,
//   and last_result_o copied from the item.
// - Config channel (cfg_valid_i / cfg_ready_o): writes the step count, always
//   ready; write it only while no item is in flight.
// Timing: each configured step runs a division over D = INPUT_BITS +
//   2*FRAC_BITS dividend bits, then an update; a new item is taken only after
//   the result of the last one is loaded into the output register. The
//   bit-serial restoring divider makes one quotient bit a cycle; a zero input skips all steps.
// Stall: the result sits in an output register, so the next item is accepted
//   and computed while it waits; only the hand-off of the next finished result
//   waits for out_ready_i.
// Reset: rst_ni clears the sequencer and output valid and sets the step
//   count to 10.
module newton_square_root
  import nsr_pkg::*;
#(
  parameter int FRAC_BITS  = FracBitsDefault,
  parameter int INPUT_BITS = InputBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INPUT_BITS-1:0] value_i,
  input  logic                  last_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RootW-1:0]      root_o,
  output logic                  last_result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IterW-1:0]      cfg_data_i
);

  // Dividend width: value shifted left by twice the fraction bits.
  localparam int DivBits = INPUT_BITS + 2 * FRAC_BITS;

  nsr_cmd_t    cmd;
  nsr_status_t status;

  nsr_ctrl #(
    .DIV_BITS(DivBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Guess, divider and output registers.
  nsr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INPUT_BITS(INPUT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .value_i      (value_i),
    .last_item_i  (last_item_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .root_o       (root_o),
    .last_result_o(last_result_o)
  );

endmodule
